>>> rtl/mwbe_pkg.sv
// Shared types, constants and helpers for the MFSK Walsh block encoder.
// No dependencies; imported by the front, back and top-level modules.
`default_nettype none

package mwbe_pkg;

  // Scrambler words, read from bit 0 upward, one bit per tone
  localparam logic [63:0] ScramblerOlivia    = 64'hE257_E6D0_2915_74EC;
  localparam logic [63:0] ScramblerContestia = 64'h0000_0000_EDB8_8320;

  // Register indexes of the configuration port
  localparam logic RegIdxMode = 1'b0;

  // Queue depths
  localparam int CmdDepthDefault = 2;
  localparam int OutDepthDefault = 2;

  // Classified character, handed from front to back
  typedef struct packed {
    logic       olivia;  // 64 tones, 8 bytes
    logic       neg;     // negative impulse
    logic [5:0] idx;     // impulse position
  } cmd_t;

  // One result item
  typedef struct packed {
    logic [7:0] tone_byte;
    logic       last;
  } out_t;

  // Scrambler bits for tones 8*k .. 8*k+7
  function automatic logic [7:0] scr_byte(input logic olivia, input logic [2:0] k);
    logic [63:0] s;
    s = olivia ? ScramblerOlivia : ScramblerContestia;
    return s[{k, 3'b000} +: 8];
  endfunction

endpackage

`default_nettype wire

>>> rtl/mwbe_queue.sv
// Small synchronous FIFO with registered count; used between stages.
// Depends on nothing but its parameters.
`default_nettype none

module mwbe_queue #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [Width-1:0]      data_o,
  output logic                  empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             wr, rd;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign wr      = push_i & ~full_o;
  assign rd      = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr && !rd) begin
      count_d = count_q + 1'b1;
    end else if (rd && !wr) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/mwbe_front.sv
// Front end: maps and masks the incoming character into impulse sign/position.
// Depends on mwbe_pkg (cmd_t).
`default_nettype none

module mwbe_front
  import mwbe_pkg::*;
(
  input  wire logic [7:0] character_i,
  input  wire logic       olivia_i,
  output cmd_t            cmd_o
);

  localparam logic [7:0] CodeSpace = 8'd59;
  localparam logic [7:0] CodeEol   = 8'd60;
  localparam logic [7:0] CodeBs    = 8'd61;
  localparam logic [7:0] CodeOther = 8'd31;
  localparam logic [7:0] ChCr      = 8'd13;
  localparam logic [7:0] ChLf      = 8'd10;
  localparam logic [7:0] ChBs      = 8'd8;
  localparam logic [7:0] ChSpace   = 8'h20;

  logic [7:0] up, mapped;

  // Contestia alphabet
  always_comb begin
    up = character_i;
    if (character_i inside {[8'h61:8'h7A]}) begin
      up = character_i - 8'h20;
    end
    if (up inside {[8'h21:8'h5A]}) begin
      mapped = up - 8'h20;
    end else if (up == ChSpace) begin
      mapped = CodeSpace;
    end else if (up == ChCr || up == ChLf) begin
      mapped = CodeEol;
    end else if (up == ChBs) begin
      mapped = CodeBs;
    end else if (up == 8'h00) begin
      mapped = 8'h00;
    end else begin
      mapped = CodeOther;
    end
  end

  always_comb begin
    cmd_o.olivia = olivia_i;
    if (olivia_i) begin
      cmd_o.neg = character_i[6];
      cmd_o.idx = character_i[5:0];
    end else begin
      cmd_o.neg = mapped[5];
      cmd_o.idx = {1'b0, mapped[4:0]};
    end
  end

endmodule

`default_nettype wire

>>> rtl/mwbe_back.sv
// Back end: builds the tone bits of a block, one byte per cycle when not stalled.
// Depends on mwbe_pkg (cmd_t, out_t, scr_byte).
`default_nettype none

module mwbe_back
  import mwbe_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cmd_t cmd_i,
  input  wire logic cmd_empty_i,
  output logic      cmd_pop_o,
  output logic      out_push_o,
  output out_t      out_o,
  input  wire logic out_full_i
);

  logic [2:0] k_q, k_d;
  logic [2:0] k_last;
  logic [7:0] scr;
  logic [7:0] tones;
  logic       step;

  assign k_last = cmd_i.olivia ? 3'd7 : 3'd3;
  assign step   = ~cmd_empty_i & ~out_full_i;
  assign scr    = scr_byte(cmd_i.olivia, k_q);

  // tone j = ~(scr[j] ^ neg ^ parity(~j & idx))
  always_comb begin
    logic [5:0] j;
    for (int b = 0; b < 8; b++) begin
      j        = {k_q, 3'(b)};
      tones[b] = ~(scr[b] ^ cmd_i.neg ^ (^(~j & cmd_i.idx)));
    end
  end

  assign out_push_o      = step;
  assign out_o.tone_byte = tones;
  assign out_o.last      = (k_q == k_last);
  assign cmd_pop_o       = step & (k_q == k_last);

  always_comb begin
    k_d = k_q;
    if (step) begin
      k_d = (k_q == k_last) ? 3'd0 : k_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= 3'd0;
    end else begin
      k_q <= k_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/mfsk_walsh_block_encoder.sv
// Top level of the Olivia/Contestia MFSK block encoder.
// Depends on mwbe_pkg, mwbe_front, mwbe_queue, mwbe_back.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+---------------------------
//  input    | in        | push / full          | character_i[7:0]
//  result   | out       | pop / empty          | tone_byte_o[7:0], last_o
//  config   | in/out    | psel/penable/pready  | mode (bit 0 at addr 0)
//
// Each character becomes 8 result items (Olivia) or 4 (Contestia); the back
// end makes one item per cycle while the result queue has room, stepped by
// the byte sequencer. Characters are taken every cycle while the command
// queue has room; the first item passes through the command queue and then
// the result queue, both registered, before it reaches the result ports.
// Reset (rst_ni low, async) empties both queues and sets mode to Contestia.
// A stalled result holds on the ports; the front keeps filling its queue.
`default_nettype none

module mfsk_walsh_block_encoder
  import mwbe_pkg::*;
#(
  parameter int CmdDepth = CmdDepthDefault,
  parameter int OutDepth = OutDepthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input items
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  character_i,
  // result items
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       tone_byte_o,
  output logic             last_o,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic mode_q, mode_d;
  logic cfg_wr;

  cmd_t cmd_in, cmd_out;
  logic cmd_empty, cmd_pop;
  out_t out_in, out_out;
  logic out_push, out_full;

  // --- configuration: one register, index from paddr[2] ---
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr[2] == RegIdxMode) ? {31'b0, mode_q} : 32'b0;

  always_comb begin
    mode_d = mode_q;
    if (cfg_wr && paddr[2] == RegIdxMode) begin
      mode_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
    end
  end

  // --- front: classify each item as it arrives ---
  mwbe_front u_front (
    .character_i (character_i),
    .olivia_i    (mode_q),
    .cmd_o       (cmd_in)
  );

  mwbe_queue #(
    .Width ($bits(cmd_t)),
    .Depth (CmdDepth)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  // --- back: byte sequencer ---
  mwbe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_out),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .out_push_o  (out_push),
    .out_o       (out_in),
    .out_full_i  (out_full)
  );

  // --- result queue decouples the sequencer from pop ---
  mwbe_queue #(
    .Width ($bits(out_t)),
    .Depth (OutDepth)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (out_in),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_out),
    .empty_o (empty)
  );

  assign tone_byte_o = out_out.tone_byte;
  assign last_o      = out_out.last;

endmodule

`default_nettype wire

>>> rtl/mwbe_checker.sv
// Port-level checks for the MFSK Walsh block encoder, bound to the top level.
// Depends on mfsk_walsh_block_encoder port names only.
`default_nettype none

module mwbe_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [7:0]  tone_byte_o,
  input wire logic        last_o,
  input wire logic        psel,
  input wire logic        penable,
  input wire logic        pwrite,
  input wire logic [2:0]  paddr,
  input wire logic [31:0] pwdata,
  input wire logic [31:0] prdata,
  input wire logic        pready
);

  // held result stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(tone_byte_o) && $stable(last_o))
    else $error("result changed while stalled");

  // nothing waits during reset
  a_rst_empty: assert property (@(posedge clk_i) !rst_ni |-> empty)
    else $error("result visible during reset");

  // mode write reads back
  a_mode_rb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && paddr[2] == 1'b0
    |=> paddr[2] != 1'b0 || prdata == {31'b0, $past(pwdata[0])})
    else $error("mode readback mismatch");

  // no wait states
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind mfsk_walsh_block_encoder mwbe_checker u_mwbe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .empty       (empty),
  .pop         (pop),
  .tone_byte_o (tone_byte_o),
  .last_o      (last_o),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .paddr       (paddr),
  .pwdata      (pwdata),
  .prdata      (prdata),
  .pready      (pready)
);

`default_nettype wire

>>> sim/tb_mfsk_walsh_block_encoder.sv
// Self-checking testbench for the Olivia/Contestia MFSK block encoder.
// Depends on mwbe_pkg (register index) and the RTL top, mfsk_walsh_block_encoder.
// The tone-byte scoreboard class and all drivers are kept in this one file.
`timescale 1ns / 1ps

module tb_mfsk_walsh_block_encoder;
  import mwbe_pkg::*;

  // Tone-set selection, as held in the mode register
  typedef enum logic {
    ModeContestia = 1'b0,
    ModeOlivia    = 1'b1
  } tone_mode_e;

  // One predicted result item
  typedef struct packed {
    logic [7:0] tone_byte;
    logic       last;
  } tone_item_t;

  // Register map: mode at its index, one word above it lies outside the map
  localparam logic [2:0] ModeAddr  = {RegIdxMode, 2'b00};
  localparam logic [2:0] SpareAddr = 3'd4;

  localparam int ClkHalfPeriod = 2;
  localparam int ResetCycles   = 4;
  localparam int SettleCycles  = 4;    // margin after the last checked item
  localparam int WatchdogLimit = 2000; // cycles with no item moving
  localparam int RandomPerMode = 68;

  //==========================================================================
  // Scoreboard: predicts the tone bytes of each accepted character and
  // checks the result items against them in order.
  //==========================================================================
  class tone_scoreboard;
    localparam logic [63:0] ScrOlivia    = 64'hE257_E6D0_2915_74EC;
    localparam logic [63:0] ScrContestia = 64'h0000_0000_EDB8_8320;
    localparam logic [7:0]  ChrBs        = 8'h08;
    localparam logic [7:0]  ChrLf        = 8'h0A;
    localparam logic [7:0]  ChrCr        = 8'h0D;
    localparam logic [5:0]  SymSpace     = 6'd59;
    localparam logic [5:0]  SymNewline   = 6'd60;
    localparam logic [5:0]  SymBackspace = 6'd61;
    localparam logic [5:0]  SymUnknown   = 6'd31;

    tone_mode_e mode = ModeContestia;
    tone_item_t expected_q[$];
    int errors;
    int chars_contestia;
    int chars_olivia;
    int bytes_checked;

    function void set_mode(tone_mode_e m);
      mode = m;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Reduced Contestia alphabet
    function logic [5:0] contestia_symbol(logic [7:0] c);
      logic [7:0] u;
      u = c;
      if (u >= "a" && u <= "z") u = u - 8'h20;
      if (u >= "!" && u <= "Z") return 6'(u - 8'd32);
      if (u == " ") return SymSpace;
      if (u == ChrCr || u == ChrLf) return SymNewline;
      if (u == ChrBs) return SymBackspace;
      if (u == 8'h00) return 6'd0;
      return SymUnknown;
    endfunction

    function void note_character(logic [7:0] c);
      logic [6:0]  v;
      logic [5:0]  idx;
      logic [5:0]  tone_mask;
      logic [5:0]  jj;
      logic [63:0] scr;
      logic [63:0] tones;
      logic        neg;
      logic        positive;
      int          n;
      tone_item_t  item;
      if (mode == ModeOlivia) begin
        n         = 64;
        scr       = ScrOlivia;
        tone_mask = 6'h3F;
        v         = c[6:0];
        neg       = v[6];
        idx       = v[5:0];
        chars_olivia++;
      end else begin
        n         = 32;
        scr       = ScrContestia;
        tone_mask = 6'h1F;
        v         = {1'b0, contestia_symbol(c)};
        neg       = v[5];
        idx       = {1'b0, v[4:0]};
        chars_contestia++;
      end
      tones = '0;
      // Walsh row sign is the parity of ~j & idx, flipped by a negative impulse
      for (int j = 0; j < n; j++) begin
        jj       = j[5:0];
        positive = neg ^ (^(~jj & idx & tone_mask));
        tones[j] = scr[j] ? positive : !positive;
      end
      for (int k = 0; k < n / 8; k++) begin
        item.tone_byte = tones[8*k +: 8];
        item.last      = (k == n / 8 - 1);
        expected_q.push_back(item);
      end
    endfunction

    function void check_result(logic [7:0] tone_byte, logic last);
      tone_item_t exp_item;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected item, tone_byte %02h last %b", $time, tone_byte, last);
        errors++;
        return;
      end
      exp_item = expected_q.pop_front();
      bytes_checked++;
      if (tone_byte !== exp_item.tone_byte) begin
        $display("%0t: tone_byte mismatch, expected %02h actual %02h",
                 $time, exp_item.tone_byte, tone_byte);
        errors++;
      end
      if (last !== exp_item.last) begin
        $display("%0t: last mismatch, expected %b actual %b", $time, exp_item.last, last);
        errors++;
      end
    endfunction
  endclass

  //==========================================================================
  // Signals and DUT
  //==========================================================================
  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [7:0]  character_i;
  logic        empty;
  logic        pop;
  logic [7:0]  tone_byte_o;
  logic        last_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  tone_scoreboard sb = new();

  // Per-cycle idle chances in percent, changed between phases
  int send_idle_pct;
  int recv_idle_pct;
  int quiet_cycles;

  mfsk_walsh_block_encoder u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .character_i(character_i),
    .empty      (empty),
    .pop        (pop),
    .tone_byte_o(tone_byte_o),
    .last_o     (last_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #ClkHalfPeriod clk_i = ~clk_i;
  end

  //==========================================================================
  // Result side: pop is redrawn every edge; an item counts when pop was high
  // and empty low just before the edge.
  //==========================================================================
  initial begin
    pop <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && !empty) sb.check_result(tone_byte_o, last_o);
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: any item, config access or reset keeps it quiet
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t: watchdog expired with %0d items outstanding", $time, sb.pending());
      $display("DONE: errors detected");
      $finish;
    end
  end

  //==========================================================================
  // Drivers. Every task is entered just after a rising edge.
  //==========================================================================

  // push is left high after acceptance so back-to-back items never toggle it
  // within one step; it drops on a deliberate idle cycle or at the end of a run.
  task automatic send_character(input logic [7:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push        <= 1'b1;
    character_i <= c;
    do @(posedge clk_i); while (full);
    sb.note_character(c);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == ModeAddr) sb.set_mode(tone_mode_e'(data[0]));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mode read-back: only bit 0 is backed by storage
  task automatic check_mode_readback();
    logic [31:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ModeAddr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    if (rd !== {31'b0, sb.mode}) begin
      $display("%0t: mode read-back mismatch, expected %08h actual %08h",
               $time, {31'b0, sb.mode}, rd);
      sb.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Config may only change once every block has come out
  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Mix of raw bytes, letters, mapped specials and printable ASCII
  function automatic logic [7:0] pick_character();
    case ($urandom_range(3))
      0: return 8'($urandom_range(255));
      1: return $urandom_range(1) ? 8'($urandom_range("a", "z")) : 8'($urandom_range("A", "Z"));
      2: begin
        case ($urandom_range(11))
          0:  return 8'h00;
          1:  return tone_scoreboard::ChrBs;
          2:  return tone_scoreboard::ChrLf;
          3:  return tone_scoreboard::ChrCr;
          4:  return " ";
          5:  return "!";
          6:  return "Z";
          7:  return "a";
          8:  return "z";
          9:  return 8'h7F;
          10: return 8'h80;
          default: return 8'hFF;
        endcase
      end
      default: return 8'($urandom_range(8'h20, 8'h7E));
    endcase
  endfunction

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) send_character(pick_character());
    push <= 1'b0;
  endtask

  //==========================================================================
  // Main sequence
  //==========================================================================
  logic [7:0] contestia_directed[16] = '{
    8'h00, 8'hFF, 8'h80, 8'h7F, "a", "z", "A", "Z", "!", " ",
    tone_scoreboard::ChrCr, tone_scoreboard::ChrLf, tone_scoreboard::ChrBs,
    "?", "~", 8'h01
  };
  // Olivia: both halves of the 7-bit code, and the high-bit wrap
  logic [7:0] olivia_directed[9] = '{
    8'h00, 8'h7F, 8'h80, 8'hFF, 8'h3F, 8'h40, 8'h55, 8'hAA, 8'h01
  };

  initial begin
    rst_ni        <= 1'b0;
    push          <= 1'b0;
    character_i   <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    send_idle_pct = 26;
    recv_idle_pct = 53;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset mode is Contestia, so the mapping cases go first
    check_mode_readback();
    foreach (contestia_directed[i]) send_character(contestia_directed[i]);
    push <= 1'b0;
    wait_drained();

    // Upper bits of the write data must be ignored
    write_reg(ModeAddr, 32'hFFFF_FFFF);
    check_mode_readback();
    foreach (olivia_directed[i]) send_character(olivia_directed[i]);
    push <= 1'b0;
    wait_drained();

    // Random: three idle profiles, both modes under each
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          send_idle_pct = 26;
          recv_idle_pct = 53;
        end
        1: begin
          send_idle_pct = 53;
          recv_idle_pct = 26;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      write_reg(ModeAddr, (p == 1) ? 32'hFFFF_FFFE : {31'b0, ModeContestia});
      // An address outside the map must leave mode alone
      if (p == 0) write_reg(SpareAddr, 32'hFFFF_FFFF);
      check_mode_readback();
      send_random(RandomPerMode);
      wait_drained();

      write_reg(ModeAddr, {31'b0, ModeOlivia});
      check_mode_readback();
      send_random(RandomPerMode);
      wait_drained();
    end

    $display("Encoded %0d Contestia and %0d Olivia characters, %0d tone bytes checked",
             sb.chars_contestia, sb.chars_olivia, sb.bytes_checked);
    $display("Both modes under sender/receiver stalls and at full rate, %0d errors",
             sb.errors);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/mwbe_pkg.sv
rtl/mwbe_queue.sv
rtl/mwbe_front.sv
rtl/mwbe_back.sv
rtl/mfsk_walsh_block_encoder.sv
rtl/mwbe_checker.sv
sim/tb_mfsk_walsh_block_encoder.sv
